// ===== design/assert_macros.svh =====
// Shared assertion macros, clocked on clk_i with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define WENO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("weno3 assertion failed");

`define WENO_ASSERT_IMP(lbl, ante, cons) \
  `WENO_ASSERT(lbl, (ante) |-> (cons))

`define WENO_ASSERT_NXT(lbl, ante, cons) \
  `WENO_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== design/weno3_pkg.sv =====
// ----------------------------------------------------------------------------
// weno3_pkg
// Types and constants shared by the WENO3 face reconstruction block.
// ----------------------------------------------------------------------------
`default_nettype none

package weno3_pkg;

  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned INV_WIDTH    = 32;
  localparam int unsigned OFFSET_WIDTH = 16;
  localparam int unsigned NORM_BITS    = 30;

  localparam logic [INV_WIDTH-1:0]    INV_SPACING_RST   = 32'd65536;
  localparam logic [OFFSET_WIDTH-1:0] WEIGHT_OFFSET_RST = 16'd1;

  typedef enum logic [0:0] {
    CFG_INV_SPACING   = 1'b0,
    CFG_WEIGHT_OFFSET = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] cell_value;
    logic                          line_first;
    logic                          line_final;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] slope;
    logic signed [VALUE_WIDTH-1:0] curvature_term;
    logic                          run_end;
  } out_beat_t;

  typedef struct packed {
    logic ld_pend;
    logic ld_ops;
    logic ops_last;
    logic win_shift;
    logic win_restart;
    logic en_sq;
    logic en_ind;
    logic en_norm;
    logic en_sqx;
    logic en_div_init;
    logic en_div;
    logic en_face;
    logic en_mul;
    logic en_fin;
    logic ld_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic out_free;
  } dpath_status_t;

endpackage

`default_nettype wire

// ===== design/weno3_ctrl.sv =====
// ----------------------------------------------------------------------------
// weno3_ctrl
// Sequencer: window bookkeeping, line state and step commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module weno3_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_first_i,
  input  wire logic                      in_final_i,
  output logic                           in_stall_o,
  input  wire weno3_pkg::dpath_status_t  status_i,
  output weno3_pkg::ctrl_cmd_t           cmd_o
);
  import weno3_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned CW = $clog2(FRAC_BITS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_LAST = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_IND  = 4'd4;
  localparam logic [3:0] S_NORM = 4'd5;
  localparam logic [3:0] S_SQX  = 4'd6;
  localparam logic [3:0] S_DIVI = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FACE = 4'd9;
  localparam logic [3:0] S_MUL  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]    state_q, state_d;
  logic          fill_q, fill_d;
  logic          second_q, second_d;
  logic          first_q, first_d;
  logic          final_q, final_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    second_d = second_q;
    first_d  = first_q;
    final_d  = final_q;
    cnt_d    = cnt_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.ld_pend = 1'b1;
          first_d       = in_first_i;
          final_d       = in_final_i;
          state_d       = S_PREP;
        end
      end
      S_PREP: begin
        if (fill_q && !first_q) begin
          cmd_o.ld_ops    = 1'b1;
          cmd_o.win_shift = 1'b1;
          second_d        = final_q;
          state_d         = S_SQ;
        end else begin
          cmd_o.win_restart = 1'b1;
          fill_d            = 1'b1;
          state_d           = final_q ? S_LAST : S_IDLE;
        end
      end
      S_LAST: begin
        cmd_o.ld_ops   = 1'b1;
        cmd_o.ops_last = 1'b1;
        fill_d         = 1'b0;
        second_d       = 1'b0;
        state_d        = S_SQ;
      end
      S_SQ: begin
        cmd_o.en_sq = 1'b1;
        state_d     = S_IND;
      end
      S_IND: begin
        cmd_o.en_ind = 1'b1;
        state_d      = S_NORM;
      end
      S_NORM: begin
        cmd_o.en_norm = 1'b1;
        if (status_i.norm_done) begin
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        cmd_o.en_sqx = 1'b1;
        state_d      = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.en_div_init = 1'b1;
        cnt_d             = '0;
        state_d           = S_DIV;
      end
      S_DIV: begin
        cmd_o.en_div = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CW'(FRAC_BITS - 1)) begin
          state_d = S_FACE;
        end
      end
      S_FACE: begin
        cmd_o.en_face = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.en_mul = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        cmd_o.en_fin = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = second_q ? S_LAST : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= 1'b0;
      second_q <= 1'b0;
      first_q  <= 1'b0;
      final_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      second_q <= second_d;
      first_q  <= first_d;
      final_q  <= final_d;
      cnt_q    <= cnt_d;
    end
  end

  `WENO_ASSERT_NXT(a_accept_prep, accept, state_q == S_PREP)
  `WENO_ASSERT(a_cnt_range, cnt_q <= CW'(FRAC_BITS))
  `WENO_ASSERT_NXT(a_last_closes, state_q == S_LAST, !fill_q && state_q == S_SQ)

endmodule

`default_nettype wire

// ===== design/weno3_dpath.sv =====
// ----------------------------------------------------------------------------
// weno3_dpath
// Window registers, indicators, weight dividers, face values, output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module weno3_dpath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire weno3_pkg::ctrl_cmd_t                 cmd_i,
  output weno3_pkg::dpath_status_t                  status_o,
  input  wire logic signed [weno3_pkg::VALUE_WIDTH-1:0] in_value_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [0:0]                           cfg_index_i,
  input  wire logic [weno3_pkg::INV_WIDTH-1:0]      cfg_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output weno3_pkg::out_beat_t                      out_beat_o
);
  import weno3_pkg::*;

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned NB  = NORM_BITS;
  localparam int unsigned IW  = 2 * W + 3;
  localparam int unsigned RW  = 2 * NB + 3;
  localparam int unsigned HW  = W + 3;
  localparam int unsigned HDW = W + 4;
  localparam int unsigned PW  = W + F + 6;
  localparam int unsigned DPW = PW + 1;
  localparam int unsigned MPW = DPW + 17;
  localparam int unsigned SLW = DPW + 33;
  localparam int unsigned CVW = PW + 2;
  localparam int unsigned HALF = INV_WIDTH / 2;

  localparam logic signed [SLW-1:0] SL_RND = SLW'(1) << (2 * F);
  localparam logic signed [SLW-1:0] SL_MAX = {{(SLW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SLW-1:0] SL_MIN = {{(SLW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [CVW-1:0] CV_RND = CVW'(1) << (F + 1);
  localparam logic signed [CVW-1:0] CV_MAX = {{(CVW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [CVW-1:0] CV_MIN = {{(CVW-W+1){1'b1}}, {(W-1){1'b0}}};

  // configuration and control
  logic [INV_WIDTH-1:0]    inv_q;
  logic [OFFSET_WIDTH-1:0] off_q;
  logic                    out_valid_q;
  out_beat_t               out_q;

  // window and operands
  logic signed [W-1:0] pend_q, left_q, centre_q;
  logic signed [W-1:0] op_a_q, op_c_q, op_b_q;
  logic                op_end_q;

  // squares and half sums
  logic [2*W-1:0] sq_a_q, sq_b_q, sq_c_q;
  logic [2*W:0]   sq_ac_q, sq_bc_q;
  logic signed [HW-1:0] h1m_q, h2m_q, h1p_q, h2p_q;
  logic signed [2*W-1:0] sa, sb, sc;
  logic signed [W:0]     dac, dbc;
  logic signed [2*W+1:0] sac, sbc;

  // indicators
  logic [IW-1:0] b1m_q, b2m_q, b1p_q, b2p_q;
  logic [IW-1:0] tw_a, tw_b, tw_c;
  logic          done_m, done_p;

  // weights
  logic [NB-1:0]   xm, ym, xp, yp;
  logic [2*NB-1:0] xm2_q, ym2_q, xp2_q, yp2_q;
  logic [RW-1:0]   nm, dm, np, dp;
  logic [RW-1:0]   dm_q, dp_q, rm_q, rp_q, rm2, rp2;
  logic [F:0]      wm_q, wp_q;

  // faces and results
  logic signed [HDW-1:0] hdm, hdp;
  logic signed [PW-1:0]  wdm, wdp, pm_q, pp_q;
  logic signed [DPW-1:0] dpf;
  logic signed [MPW-1:0] plo_q, phi_q;
  logic signed [CVW-1:0] cv_q, cv_sh;
  logic signed [SLW-1:0] sl_full, sl_sh;
  logic signed [W-1:0]   res_sl_q, res_cv_q;
  logic                  res_end_q;

  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_beat_o         = out_q;

  assign sa  = op_a_q * op_a_q;
  assign sb  = op_b_q * op_b_q;
  assign sc  = op_c_q * op_c_q;
  assign dac = (W+1)'(op_a_q) - (W+1)'(op_c_q);
  assign dbc = (W+1)'(op_b_q) - (W+1)'(op_c_q);
  assign sac = dac * dac;
  assign sbc = dbc * dbc;

  assign tw_a = (IW'(sq_a_q) << 3) + (IW'(sq_a_q) << 2);
  assign tw_b = (IW'(sq_b_q) << 3) + (IW'(sq_b_q) << 2);
  assign tw_c = (IW'(sq_c_q) << 3) + (IW'(sq_c_q) << 2);

  assign done_m = (b1m_q[IW-1:NB] == '0) && (b2m_q[IW-1:NB] == '0);
  assign done_p = (b1p_q[IW-1:NB] == '0) && (b2p_q[IW-1:NB] == '0);
  assign status_o.norm_done = done_m && done_p;

  always_comb begin
    xm = b1m_q[NB-1:0];
    ym = b2m_q[NB-1:0];
    xp = b1p_q[NB-1:0];
    yp = b2p_q[NB-1:0];
    if (xm == '0 && ym == '0) begin
      xm = NB'(1);
      ym = NB'(1);
    end
    if (xp == '0 && yp == '0) begin
      xp = NB'(1);
      yp = NB'(1);
    end
  end

  assign nm  = RW'({ym2_q, 1'b0});
  assign dm  = nm + RW'(xm2_q);
  assign np  = RW'(yp2_q);
  assign dp  = np + RW'({xp2_q, 1'b0});
  assign rm2 = {rm_q[RW-2:0], 1'b0};
  assign rp2 = {rp_q[RW-2:0], 1'b0};

  assign hdm = HDW'(h1m_q) - HDW'(h2m_q);
  assign hdp = HDW'(h1p_q) - HDW'(h2p_q);
  assign wdm = $signed({1'b0, wm_q}) * hdm;
  assign wdp = $signed({1'b0, wp_q}) * hdp;
  assign dpf = DPW'(pp_q) - DPW'(pm_q);

  assign sl_full = SLW'(plo_q) + (SLW'(phi_q) <<< HALF);
  assign sl_sh   = (sl_full + SL_RND) >>> (2 * F + 1);
  assign cv_sh   = (cv_q + CV_RND) >>> (F + 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q       <= INV_SPACING_RST;
      off_q       <= WEIGHT_OFFSET_RST;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.ld_out || (out_valid_q && out_stall_i);
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_INV_SPACING:   inv_q <= cfg_data_i;
          CFG_WEIGHT_OFFSET: off_q <= cfg_data_i[OFFSET_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_pend) begin
      pend_q <= in_value_i;
    end
    if (cmd_i.ld_ops) begin
      op_a_q   <= left_q;
      op_c_q   <= centre_q;
      op_b_q   <= cmd_i.ops_last ? centre_q : pend_q;
      op_end_q <= cmd_i.ops_last;
    end
    if (cmd_i.win_shift) begin
      left_q   <= centre_q;
      centre_q <= pend_q;
    end else if (cmd_i.win_restart) begin
      left_q   <= pend_q;
      centre_q <= pend_q;
    end
    if (cmd_i.en_sq) begin
      sq_a_q  <= sa;
      sq_b_q  <= sb;
      sq_c_q  <= sc;
      sq_ac_q <= sac[2*W:0];
      sq_bc_q <= sbc[2*W:0];
      h1m_q   <= HW'(op_c_q) + HW'(op_a_q);
      h2m_q   <= (HW'(op_c_q) <<< 1) + HW'(op_c_q) - HW'(op_b_q);
      h1p_q   <= (HW'(op_c_q) <<< 1) + HW'(op_c_q) - HW'(op_a_q);
      h2p_q   <= HW'(op_c_q) + HW'(op_b_q);
    end
    if (cmd_i.en_ind) begin
      b1m_q <= tw_a + IW'(sq_ac_q) + IW'(off_q);
      b2m_q <= tw_b + IW'(sq_bc_q) + IW'(off_q);
      b1p_q <= tw_c + IW'(sq_ac_q) + IW'(off_q);
      b2p_q <= tw_c + IW'(sq_bc_q) + IW'(off_q);
    end else if (cmd_i.en_norm) begin
      if (!done_m) begin
        b1m_q <= b1m_q >> 1;
        b2m_q <= b2m_q >> 1;
      end
      if (!done_p) begin
        b1p_q <= b1p_q >> 1;
        b2p_q <= b2p_q >> 1;
      end
    end
    if (cmd_i.en_sqx) begin
      xm2_q <= xm * xm;
      ym2_q <= ym * ym;
      xp2_q <= xp * xp;
      yp2_q <= yp * yp;
    end
    if (cmd_i.en_div_init) begin
      dm_q <= dm;
      dp_q <= dp;
      wm_q <= (nm >= dm) ? (F+1)'(1) : '0;
      wp_q <= (np >= dp) ? (F+1)'(1) : '0;
      rm_q <= (nm >= dm) ? nm - dm : nm;
      rp_q <= (np >= dp) ? np - dp : np;
    end else if (cmd_i.en_div) begin
      if (rm2 >= dm_q) begin
        rm_q <= rm2 - dm_q;
        wm_q <= {wm_q[F-1:0], 1'b1};
      end else begin
        rm_q <= rm2;
        wm_q <= {wm_q[F-1:0], 1'b0};
      end
      if (rp2 >= dp_q) begin
        rp_q <= rp2 - dp_q;
        wp_q <= {wp_q[F-1:0], 1'b1};
      end else begin
        rp_q <= rp2;
        wp_q <= {wp_q[F-1:0], 1'b0};
      end
    end
    if (cmd_i.en_face) begin
      pm_q <= (PW'(h2m_q) <<< F) + wdm;
      pp_q <= (PW'(h2p_q) <<< F) + wdp;
    end
    if (cmd_i.en_mul) begin
      plo_q <= dpf * $signed({1'b0, inv_q[HALF-1:0]});
      phi_q <= dpf * $signed({1'b0, inv_q[INV_WIDTH-1:HALF]});
      cv_q  <= CVW'(pp_q) + CVW'(pm_q) - (CVW'(op_c_q) <<< (F + 2));
    end
    if (cmd_i.en_fin) begin
      if (sl_sh > SL_MAX) begin
        res_sl_q <= SL_MAX[W-1:0];
      end else if (sl_sh < SL_MIN) begin
        res_sl_q <= SL_MIN[W-1:0];
      end else begin
        res_sl_q <= sl_sh[W-1:0];
      end
      if (cv_sh > CV_MAX) begin
        res_cv_q <= CV_MAX[W-1:0];
      end else if (cv_sh < CV_MIN) begin
        res_cv_q <= CV_MIN[W-1:0];
      end else begin
        res_cv_q <= cv_sh[W-1:0];
      end
      res_end_q <= op_end_q;
    end
    if (cmd_i.ld_out) begin
      out_q.slope          <= res_sl_q;
      out_q.curvature_term <= res_cv_q;
      out_q.run_end        <= res_end_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/weno3_face_reconstruction_top.sv =====
// Steps: a result beat passes operand load, squares, indicators, a normalizing
// shift by s (0..2*VALUE_WIDTH-27) of the larger smoothness indicator, done one
// bit per cycle, weight squares, division, faces, products and final rounding.
// Throughput: one cell at a time; a cell with no result frees the input after
// the prepare state; a line-final cell with two results runs twice back to back.
// Reset: async active low; window empty, configuration registers at their reset values.
// ----------------------------------------------------------------------------
// weno3_face_reconstruction_top
// WENO3 face reconstruction along a grid line: slope and curvature per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module weno3_face_reconstruction_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire weno3_pkg::in_beat_t               in_beat_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output weno3_pkg::out_beat_t                   out_beat_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [0:0]                        cfg_index_i,
  input  wire logic [weno3_pkg::INV_WIDTH-1:0]   cfg_data_i
);
  import weno3_pkg::*;

  ctrl_cmd_t     cmd;
  dpath_status_t status;

  assign cfg_ready_o = 1'b1;

  weno3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_first_i (in_beat_i.line_first),
    .in_final_i (in_beat_i.line_final),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  weno3_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (in_beat_i.cell_value),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== bench/weno3_checker.sv =====
// ----------------------------------------------------------------------------
// weno3_checker
// Watches the cell, result and register channels of the WENO3 block. It
// tracks the clamped three-cell window and the registers, works out the
// slope and curvature beats each accepted cell gives, and compares every
// accepted result beat with the oldest one still due.
// ----------------------------------------------------------------------------
module weno3_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  weno3_pkg::in_beat_t                 in_beat_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  weno3_pkg::out_beat_t                out_beat_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [0:0]                          cfg_index_i,
  input  logic [weno3_pkg::INV_WIDTH-1:0]     cfg_data_i,
  output int                                  mismatch_count_o,
  output int                                  beats_pending_o,
  output int                                  beats_checked_o
);
  import weno3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  logic [INV_WIDTH-1:0]    inv_spacing;
  logic [OFFSET_WIDTH-1:0] weight_offset;
  logic signed [VALUE_WIDTH-1:0] left_cell, centre_cell;
  logic line_open;
  out_beat_t due_beats[$];

  assign beats_pending_o = due_beats.size();

  function automatic wide_t smoothness(input wide_t p, input wide_t q);
    wide_t off;
    off = {{(128-OFFSET_WIDTH){1'b0}}, weight_offset};
    return 13 * p * p - 2 * p * q + q * q + off;
  endfunction

  function automatic int bit_length(input wide_t v);
    for (int i = 127; i >= 0; i--) begin
      if (v[i]) return i + 1;
    end
    return 0;
  endfunction

  function automatic logic [FRAC_BITS:0] face_weight(input wide_t b1, input wide_t b2,
                                                     input int k1, input int k2);
    int   len, sh;
    logic [127:0] x, y, num, den;
    len = bit_length(b1) > bit_length(b2) ? bit_length(b1) : bit_length(b2);
    sh  = len > NORM_BITS ? len - NORM_BITS : 0;
    x = b1 >>> sh;
    y = b2 >>> sh;
    if (x == 0 && y == 0) begin
      x = 1;
      y = 1;
    end
    num = k2 * y * y;
    den = num + k1 * x * x;
    return (num << FRAC_BITS) / den;
  endfunction

  function automatic wide_t twice_face(input wide_t h1, input wide_t h2,
                                       input logic [FRAC_BITS:0] w);
    wide_t ww;
    ww = {{(127-FRAC_BITS){1'b0}}, w};
    return (h2 <<< FRAC_BITS) + ww * (h1 - h2);
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] round_sat(input wide_t v, input int sh);
    wide_t r, hi, lo;
    hi = (128'sd1 <<< (VALUE_WIDTH - 1)) - 1;
    lo = -(128'sd1 <<< (VALUE_WIDTH - 1));
    r  = (v + (128'sd1 <<< (sh - 1))) >>> sh;
    if (r < lo) return lo[VALUE_WIDTH-1:0];
    if (r > hi) return hi[VALUE_WIDTH-1:0];
    return r[VALUE_WIDTH-1:0];
  endfunction

  function automatic out_beat_t reconstruct(input logic signed [VALUE_WIDTH-1:0] ra,
                                            input logic signed [VALUE_WIDTH-1:0] rc,
                                            input logic signed [VALUE_WIDTH-1:0] rb,
                                            input logic last);
    wide_t a, c, b, p_minus, p_plus, inv;
    out_beat_t o;
    a = ra;
    c = rc;
    b = rb;
    inv = {{(128-INV_WIDTH){1'b0}}, inv_spacing};
    p_minus = twice_face(c + a, 3 * c - b,
                         face_weight(smoothness(a, c), smoothness(b, c), 1, 2));
    p_plus  = twice_face(3 * c - a, c + b,
                         face_weight(smoothness(c, a), smoothness(c, b), 2, 1));
    o.slope          = round_sat((p_plus - p_minus) * inv, 2 * FRAC_BITS + 1);
    o.curvature_term = round_sat(p_plus + p_minus - (c <<< (FRAC_BITS + 2)),
                                 FRAC_BITS + 2);
    o.run_end        = last;
    return o;
  endfunction

  task automatic report(input string what, input logic [VALUE_WIDTH-1:0] got,
                        input logic [VALUE_WIDTH-1:0] want);
    $display("%0t weno3_checker: %s got %h want %h", $realtime, what, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_spacing      = INV_SPACING_RST;
      weight_offset    = WEIGHT_OFFSET_RST;
      left_cell        = '0;
      centre_cell      = '0;
      line_open        = 1'b0;
      mismatch_count_o = 0;
      beats_checked_o  = 0;
      due_beats.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_beats.size() == 0) begin
          report("unexpected beat, slope", out_beat_i.slope, '0);
        end else begin
          out_beat_t want;
          want = due_beats.pop_front();
          if (out_beat_i.slope !== want.slope)
            report("slope", out_beat_i.slope, want.slope);
          if (out_beat_i.curvature_term !== want.curvature_term)
            report("curvature", out_beat_i.curvature_term, want.curvature_term);
          if (out_beat_i.run_end !== want.run_end)
            report("run_end", {{(VALUE_WIDTH-1){1'b0}}, out_beat_i.run_end},
                   {{(VALUE_WIDTH-1){1'b0}}, want.run_end});
        end
        beats_checked_o++;
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_beat_i.line_first || !line_open) begin
          left_cell   = in_beat_i.cell_value;
          centre_cell = in_beat_i.cell_value;
          line_open   = 1'b1;
        end else begin
          due_beats.push_back(reconstruct(left_cell, centre_cell, in_beat_i.cell_value, 1'b0));
          left_cell   = centre_cell;
          centre_cell = in_beat_i.cell_value;
        end
        if (in_beat_i.line_final) begin
          due_beats.push_back(reconstruct(left_cell, centre_cell, centre_cell, 1'b1));
          line_open = 1'b0;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_INV_SPACING:   inv_spacing   = cfg_data_i;
          CFG_WEIGHT_OFFSET: weight_offset = cfg_data_i[OFFSET_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb_weno3_face_reconstruction_top.sv =====
// ----------------------------------------------------------------------------
// tb_weno3_face_reconstruction_top
// Drives lines of cells through the WENO3 block under several register
// settings with random gaps and output stalls; the checker beside the block
// predicts every result beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb_weno3_face_reconstruction_top;
  import weno3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_beat_t in_beat_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_beat_t out_beat_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [INV_WIDTH-1:0] cfg_data_i = '0;

  int mismatch_count, beats_pending, beats_checked;
  int cells_sent = 0;
  int settings_used = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  logic signed [VALUE_WIDTH-1:0] last_cell = '0;

  weno3_face_reconstruction_top dut (.*);

  weno3_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_beat_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_beat_i(out_beat_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatch_count), .beats_pending_o(beats_pending),
    .beats_checked_o(beats_checked)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb_weno3_face_reconstruction_top: done, errors");
    $finish;
  end

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 6);
      end
    end
  end

  task automatic push_cell(input logic signed [VALUE_WIDTH-1:0] v, input logic first,
                           input logic last);
    in_valid_i <= 1'b1;
    in_beat_i  <= '{cell_value: v, line_first: first, line_final: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cells_sent++;
    last_cell = v;
    if (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (beats_pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [INV_WIDTH-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [INV_WIDTH-1:0] inv, input logic [15:0] off);
    drain();
    write_reg(CFG_INV_SPACING, inv);
    write_reg(CFG_WEIGHT_OFFSET, {16'd0, off});
    settings_used++;
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(6))
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      3: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      4: return last_cell + $signed($urandom_range(0, 4095)) - 2048;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_lines(input int count);
    int start, len;
    start = cells_sent;
    while (cells_sent - start < count) begin
      if ($urandom_range(99) < 10) begin
        push_cell(pick_value(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          push_cell(pick_value(), i == 0, i == len - 1);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    push_cell('0, 1'b1, 1'b1);
    push_cell(VMAX, 1'b1, 1'b1);
    push_cell(VMIN, 1'b1, 1'b1);
    push_cell(VMAX, 1'b1, 1'b0);
    push_cell(VMIN, 1'b0, 1'b0);
    push_cell(VMAX, 1'b0, 1'b0);
    push_cell(VMIN, 1'b0, 1'b1);
    push_cell(32'sd65536, 1'b0, 1'b0);   // no open line: starts one
    push_cell(-32'sd3, 1'b0, 1'b1);
    push_cell(32'sd100, 1'b1, 1'b0);
    push_cell(32'sd200, 1'b0, 1'b0);
    push_cell(32'sd300, 1'b1, 1'b0);     // restart drops the pending cell
    push_cell(32'sd400, 1'b0, 1'b1);
    push_cell(32'sd7, 1'b1, 1'b0);
    push_cell(32'sd7, 1'b0, 1'b0);
    push_cell(32'sd7, 1'b0, 1'b1);
    settings_used++;
    random_lines(330);

    set_regs('0, '0);
    push_cell(32'sd9, 1'b1, 1'b0);       // flat window, zero offset
    push_cell(32'sd9, 1'b0, 1'b0);
    push_cell(32'sd9, 1'b0, 1'b1);
    push_cell('0, 1'b1, 1'b1);
    calm = 1'b1;
    random_lines(340);
    calm = 1'b0;

    set_regs('1, 16'hFFFF);
    hold_req = 1'b1;
    random_lines(170);
    drain();
    random_lines(170);

    set_regs($urandom, 16'($urandom_range(65535)));
    random_lines(350);

    set_regs(32'd65536, 16'd0);
    random_lines(350);

    drain();
    $display("Covered %0d cells and %0d result beats over %0d register settings,",
             cells_sent, beats_checked, settings_used);
    $display("with edge values, line restarts, one long output hold and a calm stretch.");
    if (mismatch_count == 0) begin
      $display("tb_weno3_face_reconstruction_top: done, clean");
    end else begin
      $display("tb_weno3_face_reconstruction_top: done, errors");
    end
    $finish;
  end

endmodule
